FILE: rtl/swst_pkg.sv
// Package with the shared types, codes and sizes of the sender window tracker.
`default_nettype none
package swst_pkg;

    localparam int MAX_WINDOW = 32;
    localparam int SEQ_BITS   = 8;
    localparam int SEQ_SPACE  = 1 << SEQ_BITS;
    localparam int EFF_MAX    = (MAX_WINDOW < SEQ_SPACE) ? MAX_WINDOW : SEQ_SPACE;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W      = 6;

    typedef logic [SEQ_BITS-1:0]   seq_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [MAX_WINDOW-1:0] flags_t;

    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] KIND_SENT    = 3'd0;
    localparam logic [2:0] KIND_RETX    = 3'd1;
    localparam logic [2:0] KIND_ACK_OK  = 3'd2;
    localparam logic [2:0] KIND_ACK_IGN = 3'd3;
    localparam logic [2:0] KIND_REFUSED = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] ack_seq;
    } in_item_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] frame_seq;
        logic [5:0] outstanding;
        logic [7:0] window_base;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic adv_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic adv_more;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

FILE: rtl/swst_ctrl.sv
// Controller state machine that sequences capture, execution, base advance and output.
`default_nettype none
module swst_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire swst_pkg::status_t status,
    output swst_pkg::cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_ADV  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV: begin
                // Release one acknowledged slot per cycle, then hand off the result.
                if (status.adv_more) begin
                    cmd.adv_step = 1'b1;
                end else if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/swst_datapath.sv
// Datapath with the window state, the event logic and the output register.
`default_nettype none
module swst_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [5:0]           cfg_wdata,
    input  wire swst_pkg::in_item_t   s_data,
    input  wire swst_pkg::cmd_t       cmd,
    output swst_pkg::status_t         status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output swst_pkg::out_item_t       m_data
);

    logic [swst_pkg::WIN_W-1:0] win_reg;
    logic [1:0]                 op_reg;
    swst_pkg::seq_t             ack_reg;
    swst_pkg::seq_t             base_reg, base_next;
    swst_pkg::seq_t             nseq_reg, nseq_next;
    swst_pkg::cnt_t             cnt_reg,  cnt_next;
    swst_pkg::flags_t           flags_reg, flags_next;
    logic [2:0]                 kind_reg, kind_next;
    swst_pkg::seq_t             fseq_reg, fseq_next;
    logic                       mvalid_reg;
    swst_pkg::out_item_t        mdata_reg;

    logic [swst_pkg::CNT_W:0]   eff_win;
    swst_pkg::seq_t             off;
    logic [swst_pkg::IDX_W-1:0] off_idx;

    // Window size zero acts as one; large values saturate.
    always_comb begin
        if (win_reg == '0) begin
            eff_win = (swst_pkg::CNT_W + 1)'(1);
        end else if (32'(win_reg) > 32'(swst_pkg::EFF_MAX)) begin
            eff_win = (swst_pkg::CNT_W + 1)'(swst_pkg::EFF_MAX);
        end else begin
            eff_win = (swst_pkg::CNT_W + 1)'(win_reg);
        end
    end

    assign off     = ack_reg - base_reg;
    assign off_idx = off[swst_pkg::IDX_W-1:0];

    always_comb begin
        base_next  = base_reg;
        nseq_next  = nseq_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        kind_next  = kind_reg;
        fseq_next  = fseq_reg;
        if (cmd.exec) begin
            fseq_next = ack_reg;
            unique case (op_reg)
                swst_pkg::OP_SEND: begin
                    if (32'(cnt_reg) < 32'(eff_win)) begin
                        kind_next = swst_pkg::KIND_SENT;
                        fseq_next = nseq_reg;
                        nseq_next = nseq_reg + swst_pkg::SEQ_BITS'(1);
                        cnt_next  = cnt_reg + swst_pkg::CNT_W'(1);
                    end else begin
                        kind_next = swst_pkg::KIND_REFUSED;
                    end
                end
                swst_pkg::OP_ACK: begin
                    kind_next = swst_pkg::KIND_ACK_IGN;
                    if (32'(off) < 32'(cnt_reg) && !flags_reg[off_idx]) begin
                        kind_next           = swst_pkg::KIND_ACK_OK;
                        flags_next[off_idx] = 1'b1;
                    end
                end
                swst_pkg::OP_TIMEOUT: begin
                    kind_next = swst_pkg::KIND_RETX;
                    fseq_next = base_reg;
                end
                swst_pkg::OP_NONE: begin
                    kind_next = swst_pkg::KIND_ACK_IGN;
                end
                default: begin
                    kind_next = swst_pkg::KIND_ACK_IGN;
                end
            endcase
        end else if (cmd.adv_step) begin
            flags_next = flags_reg >> 1;
            base_next  = base_reg + swst_pkg::SEQ_BITS'(1);
            cnt_next   = cnt_reg - swst_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= swst_pkg::WIN_W'(4);
            base_reg   <= '0;
            nseq_reg   <= '0;
            cnt_reg    <= '0;
            flags_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                win_reg <= cfg_wdata;
            end
            base_reg  <= base_next;
            nseq_reg  <= nseq_next;
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
            if (cmd.load_out) begin
                mvalid_reg <= 1'b1;
            end else if (m_ready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        fseq_reg <= fseq_next;
        if (cmd.capture) begin
            op_reg  <= s_data.opcode;
            ack_reg <= swst_pkg::SEQ_BITS'(s_data.ack_seq);
        end
        if (cmd.load_out) begin
            mdata_reg.result_kind <= kind_reg;
            mdata_reg.frame_seq   <= 8'(fseq_reg);
            mdata_reg.outstanding <= 6'(cnt_reg);
            mdata_reg.window_base <= 8'(base_reg);
        end
    end

    assign status.adv_more = (cnt_reg != '0) && flags_reg[0];
    assign status.out_free = !mvalid_reg || m_ready;
    assign m_valid         = mvalid_reg;
    assign m_data          = mdata_reg;

endmodule
`default_nettype wire

FILE: rtl/sliding_window_sender_tracker_core.sv
// Top level of the sender window tracker for a selective-repeat ARQ.
//
// Each input transaction on s_* carries one event: a send request, a received
// acknowledgement or a retransmit timeout. Each event yields exactly one result
// transaction on m_*, with the result kind, the sequence number involved, the
// frame count still outstanding and the window base after the event.
// Events are handled one at a time. An event is captured in the controller's
// idle state and executed in its execute state. For every window slot that an
// acknowledgement releases (up to the frames outstanding, at most 32), the
// base then advances one slot per cycle through the controller's advance
// state, and the result is registered for m_* after that.
// A new transaction is accepted only once the previous result is registered.
// The next event may be accepted while the previous result still waits on m_*;
// if the receiver keeps m_ready low, the block finishes the event and then
// holds in its advance state until the output register frees up.
// cfg_we writes the window size; write it only while idle.
// After reset the window size is 4, base and next sequence are zero, nothing
// is outstanding, no slot is marked and no result is pending.
`default_nettype none
module sliding_window_sender_tracker_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [5:0]           cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire swst_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output swst_pkg::out_item_t       m_data
);

    swst_pkg::cmd_t    cmd;
    swst_pkg::status_t status;

    // The controller only sequences; all window state lives in the datapath.
    swst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swst_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Only one event is in flight, so acceptance is never back to back.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an event was in flight");

    // The outstanding count never exceeds the largest usable window.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.outstanding) <= 32'(swst_pkg::EFF_MAX))
        else $error("outstanding count above the window limit");

    // A frame that was just sent is counted as outstanding.
    a_sent_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == swst_pkg::KIND_SENT |->
        m_data.outstanding != '0)
        else $error("sent frame not counted as outstanding");

    // A new result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule
`default_nettype wire

FILE: tb/sv/window_tracker_sb_pkg.sv
// Scoreboard class that predicts and checks the sender window tracker results.
`timescale 1ns / 100ps
package window_tracker_sb_pkg;

    import swst_pkg::*;

    class window_tracker_sb;

        seq_t        base;
        seq_t        next_seq;
        int unsigned outstanding_cnt;
        flags_t      acked;
        logic [5:0]  window;
        out_item_t   expected_q[$];
        int unsigned errors;

        function new();
            base            = '0;
            next_seq        = '0;
            outstanding_cnt = 0;
            acked           = '0;
            window          = 6'd4;
            errors          = 0;
        endfunction

        function void set_window(logic [5:0] w);
            window = w;
        endfunction

        // A zero window behaves as one; anything above the slot count saturates.
        function int unsigned eff_window();
            int unsigned w;
            w = window;
            if (w == 0) w = 1;
            if (w > EFF_MAX) w = EFF_MAX;
            return w;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_event(in_item_t ev);
            out_item_t res;
            seq_t      off;
            res.result_kind = KIND_ACK_IGN;
            res.frame_seq   = ev.ack_seq;
            case (ev.opcode)
                OP_SEND: begin
                    if (outstanding_cnt < eff_window()) begin
                        res.result_kind = KIND_SENT;
                        res.frame_seq   = next_seq;
                        next_seq        = next_seq + 1'b1;
                        outstanding_cnt++;
                    end else begin
                        res.result_kind = KIND_REFUSED;
                    end
                end
                OP_ACK: begin
                    off = ev.ack_seq - base;
                    if (off < outstanding_cnt && !acked[off]) begin
                        res.result_kind = KIND_ACK_OK;
                        acked[off]      = 1'b1;
                        while (outstanding_cnt != 0 && acked[0]) begin
                            acked = acked >> 1;
                            base  = base + 1'b1;
                            outstanding_cnt--;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    res.result_kind = KIND_RETX;
                    res.frame_seq   = base;
                end
                default: begin
                end
            endcase
            res.outstanding = outstanding_cnt[5:0];
            res.window_base = base;
            expected_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_res;
            if (expected_q.size() == 0) begin
                $error("result with no transaction pending: %p", got);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.result_kind !== exp_res.result_kind) begin
                $error("result_kind: expected %0d, actual %0d",
                       exp_res.result_kind, got.result_kind);
                errors++;
            end
            if (got.frame_seq !== exp_res.frame_seq) begin
                $error("frame_seq: expected %0d, actual %0d",
                       exp_res.frame_seq, got.frame_seq);
                errors++;
            end
            if (got.outstanding !== exp_res.outstanding) begin
                $error("outstanding: expected %0d, actual %0d",
                       exp_res.outstanding, got.outstanding);
                errors++;
            end
            if (got.window_base !== exp_res.window_base) begin
                $error("window_base: expected %0d, actual %0d",
                       exp_res.window_base, got.window_base);
                errors++;
            end
        endfunction

    endclass

endpackage

FILE: tb/sv/tb.sv
// Top-level testbench of the sender window tracker core.
`timescale 1ns / 100ps
module tb;

    import swst_pkg::*;
    import window_tracker_sb_pkg::*;

    // Longest time an acknowledgement can keep the block busy: its handling
    // plus the advance over every released slot, with some margin.
    localparam int unsigned SETTLE_CYCLES = 48;
    // Length of the deliberate receiver hold-off that backs up the block.
    localparam int unsigned HOLD_CYCLES   = 300;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [5:0] cfg_wdata = '0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;

    window_tracker_sb sb;

    // Handshake between the stimulus and the receiver for the long hold-off.
    bit          hold_req     = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_pct    = 0;

    sliding_window_sender_tracker_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Every completed transaction on either channel is seen here at the rising
    // edge. Inputs are noted before outputs are checked, although a result at
    // a given edge always belongs to an event accepted at an earlier edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_event(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    // The receiver picks a new stall rate whenever its pattern count runs out, from
    // never stalling to stalling most of the time. A hold-off request overrides the
    // pattern and keeps m_ready low until the hold-off count runs out.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(80, 20);
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            pattern_left--;
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic in_item_t make_event(logic [1:0] op, logic [7:0] seq);
        in_item_t ev;
        ev.opcode  = op;
        ev.ack_seq = seq;
        return ev;
    endfunction

    // Random events are mostly well formed: sends that fill the window and
    // acknowledgements of frames that are really outstanding, often out of
    // order so that marked slots pile up above the base. The rest are stray
    // acknowledgements, timeouts and the unused opcode.
    function automatic in_item_t pick_event();
        in_item_t    ev;
        int unsigned r;
        ev.ack_seq = $urandom_range(255);
        r          = $urandom_range(99);
        if (r < 45) begin
            ev.opcode = OP_SEND;
        end else if (r < 85) begin
            ev.opcode = OP_ACK;
            if (sb.outstanding_cnt != 0 && r < 78) begin
                if ($urandom_range(3) == 0) begin
                    ev.ack_seq = sb.base;
                end else begin
                    ev.ack_seq = sb.base + seq_t'($urandom_range(sb.outstanding_cnt - 1));
                end
            end
        end else if (r < 93) begin
            ev.opcode = OP_TIMEOUT;
        end else begin
            ev.opcode = OP_NONE;
        end
        return ev;
    endfunction

    // Offers one event and returns at the edge where it is accepted. A random
    // event is chosen only at the falling edge, once the scoreboard has seen
    // the previous transaction, so that in-window acknowledgements track the
    // real window.
    task automatic offer(input bit pick_random, input in_item_t ev);
        @(negedge aclk);
        if (pick_random) begin
            ev = pick_event();
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Stops sending and waits until every expected result has come, then
    // lets the block settle so that it is truly idle.
    task automatic quiesce();
        idle_sender(1);
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        idle_sender(SETTLE_CYCLES);
    endtask

    task automatic write_window(input logic [5:0] w);
        quiesce();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        sb.set_window(w);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // The sender works in bursts of random length. A quarter of the bursts
    // run straight into the next one, which gives stretches with no gaps.
    task automatic run_random(input int unsigned count);
        int unsigned done;
        int unsigned burst;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(24, 1);
            while (burst != 0 && done < count) begin
                offer(1'b1, '0);
                burst--;
                done++;
            end
            if ($urandom_range(3) != 0) begin
                idle_sender($urandom_range(12, 1));
            end
        end
    endtask

    initial begin
        int unsigned phase_win[8];
        int unsigned phase_len[8];
        sb = new();
        phase_win = '{32, 1, 63, 0, 7, 32, 0, 3};
        phase_len = '{150, 60, 150, 50, 110, 150, 100, 110};
        phase_win[6] = $urandom_range(31, 2);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset window of four: a timeout and an ack
        // while nothing is outstanding, a full window and a refused send,
        // an out-of-order ack and its duplicate, an ack outside the window,
        // the unused opcode, a timeout, then acks that slide the base over marked slots.
        offer(1'b0, make_event(OP_TIMEOUT, 8'h00));
        offer(1'b0, make_event(OP_ACK, 8'h00));
        repeat (5) offer(1'b0, make_event(OP_SEND, 8'hFF));
        offer(1'b0, make_event(OP_ACK, 8'd2));
        offer(1'b0, make_event(OP_ACK, 8'd2));
        offer(1'b0, make_event(OP_ACK, 8'd200));
        offer(1'b0, make_event(OP_NONE, 8'hFF));
        offer(1'b0, make_event(OP_TIMEOUT, 8'h55));
        offer(1'b0, make_event(OP_ACK, 8'd0));
        offer(1'b0, make_event(OP_ACK, 8'd1));
        offer(1'b0, make_event(OP_ACK, 8'd3));

        // A zero window behaves as a window of one.
        write_window(6'd0);
        offer(1'b0, make_event(OP_SEND, 8'h00));
        offer(1'b0, make_event(OP_SEND, 8'h00));
        offer(1'b0, make_event(OP_ACK, 8'd4));

        // Shrink the window below the frames outstanding: sends are refused
        // while the acks still release every frame.
        write_window(6'd8);
        repeat (3) offer(1'b0, make_event(OP_SEND, 8'h00));
        write_window(6'd2);
        offer(1'b0, make_event(OP_SEND, 8'h00));
        offer(1'b0, make_event(OP_ACK, 8'd7));
        offer(1'b0, make_event(OP_ACK, 8'd6));
        offer(1'b0, make_event(OP_ACK, 8'd5));

        // Random phases over a range of window settings, the extremes and an
        // oversized value among them. The first phase also holds the receiver
        // off while the sender keeps going, so the block backs up.
        foreach (phase_win[p]) begin
            write_window(phase_win[p][5:0]);
            if (p == 0) begin
                run_random(20);
                hold_req = 1'b1;
                repeat (60) offer(1'b1, '0);
                run_random(phase_len[p] - 80);
            end else begin
                run_random(phase_len[p]);
            end
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
